// ----- src/kbr_pkg.sv -----
package kbr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_KEY  = 2'd1;
  localparam logic [1:0] REQ_CMD  = 2'd2;

  localparam logic [15:0] CMD_CLEAR   = 16'd0;
  localparam logic [15:0] CMD_POP     = 16'd1;
  localparam logic [15:0] CMD_SET_MSG = 16'd3;

  localparam logic [20:0] PRINT_LOW = 21'h20;
  localparam logic [20:0] PRINT_END = 21'h7f;

  typedef struct packed {
    logic accept;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pop;
  } dp_status_t;

endpackage

// ----- src/kbr_ram.sv -----
module kbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/kbr_ctrl.sv -----
module kbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  kbr_pkg::dp_status_t status,
  output kbr_pkg::ctrl_cmd_t  cmd
);

  kbr_pkg::state_t state;
  kbr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kbr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.is_pop ? kbr_pkg::ST_READ : kbr_pkg::ST_SEND;
        end
      end
      kbr_pkg::ST_READ: begin
        state_next = kbr_pkg::ST_SEND;
      end
      kbr_pkg::ST_SEND: begin
        if (!out_stall) begin
          state_next = kbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      kbr_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      kbr_pkg::ST_READ: begin
        cmd.capture = 1'b1;
      end
      kbr_pkg::ST_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/kbr_datapath.sv -----
module kbr_datapath #(
  parameter int RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  kbr_pkg::ctrl_cmd_t  cmd,
  output kbr_pkg::dp_status_t status,
  input  logic [1:0]          req_type,
  input  logic [20:0]         char_code,
  input  logic [7:0]          key_code,
  input  logic [15:0]         a_reg,
  input  logic [15:0]         b_reg,
  output logic                c_write,
  output logic [7:0]          c_value,
  output logic                irq_fire,
  output logic [15:0]         irq_message
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0]      write_index;
  logic [IDX_W-1:0]      read_index;
  logic [15:0]           interrupt_message;
  logic [RING_DEPTH-1:0] slot_valid;
  logic                  pop_valid;
  logic [7:0]            ram_rdata;

  logic       do_enq;
  logic       do_pop;
  logic       do_clear;
  logic       do_set;
  logic [7:0] enq_code;
  logic       char_ok;

  always_comb begin
    char_ok  = (char_code >= kbr_pkg::PRINT_LOW) && (char_code < kbr_pkg::PRINT_END);
    do_enq   = 1'b0;
    do_pop   = 1'b0;
    do_clear = 1'b0;
    do_set   = 1'b0;
    enq_code = key_code;
    case (req_type)
      kbr_pkg::REQ_CHAR: begin
        do_enq   = char_ok;
        enq_code = char_code[7:0];
      end
      kbr_pkg::REQ_KEY: begin
        do_enq = (key_code != 8'd0);
      end
      kbr_pkg::REQ_CMD: begin
        do_clear = (a_reg == kbr_pkg::CMD_CLEAR);
        do_pop   = (a_reg == kbr_pkg::CMD_POP);
        do_set   = (a_reg == kbr_pkg::CMD_SET_MSG);
      end
      default: begin
        do_enq = 1'b0;
      end
    endcase
  end

  assign status.is_pop = do_pop;

  kbr_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.accept && do_enq),
    .waddr(write_index),
    .wdata(enq_code),
    .raddr(read_index),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index       <= '0;
      read_index        <= '0;
      interrupt_message <= '0;
      slot_valid        <= '0;
    end else if (cmd.accept) begin
      if (do_enq) begin
        slot_valid[write_index] <= 1'b1;
        write_index <= (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
      end
      if (do_pop) begin
        slot_valid[read_index] <= 1'b0;
        read_index <= (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
      end
      if (do_clear) begin
        slot_valid  <= '0;
        write_index <= '0;
        read_index  <= '0;
      end
      if (do_set) begin
        interrupt_message <= b_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_valid   <= slot_valid[read_index];
      c_write     <= do_pop;
      c_value     <= 8'd0;
      irq_fire    <= do_enq && (interrupt_message != 16'd0);
      irq_message <= do_enq ? interrupt_message : 16'd0;
    end else if (cmd.capture) begin
      c_value <= pop_valid ? ram_rdata : 8'd0;
    end
  end

endmodule

// ----- src/keyboard_event_ring_device.sv -----
// Keyboard event ring device.
// Input channel (in_valid/in_stall) carries one request: a text character,
// a special key code, or a host command (clear, pop, set message).
// Output channel (out_valid/out_stall) returns exactly one result per
// request: c_write/c_value for a pop, irq_fire/irq_message for a queued key.
// A result is valid in the cycle after the request is taken; a pop passes
// through ST_READ first, which waits on the registered read of the ring RAM.
// The controller handles one request at a time and takes no new request
// until the result of the last one has been taken.
// Reset clears the pointers, the slot valid bits (every slot reads zero)
// and the interrupt message (interrupts disabled); no clearing pass runs.
// While a result is presented and out_stall is high, the result and all
// state hold and in_stall stays high.
module keyboard_event_ring_device #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [20:0] char_code,
  input  logic [7:0]  key_code,
  input  logic [15:0] a_reg,
  input  logic [15:0] b_reg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        c_write,
  output logic [7:0]  c_value,
  output logic        irq_fire,
  output logic [15:0] irq_message
);

  kbr_pkg::ctrl_cmd_t  cmd;
  kbr_pkg::dp_status_t status;

  kbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kbr_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req_type),
    .char_code  (char_code),
    .key_code   (key_code),
    .a_reg      (a_reg),
    .b_reg      (b_reg),
    .c_write    (c_write),
    .c_value    (c_value),
    .irq_fire   (irq_fire),
    .irq_message(irq_message)
  );

endmodule

// ----- verif/kbr_ring_checker.sv -----
module kbr_ring_checker #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [20:0] char_code,
  input  logic [7:0]  key_code,
  input  logic [15:0] a_reg,
  input  logic [15:0] b_reg,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        c_write,
  input  logic [7:0]  c_value,
  input  logic        irq_fire,
  input  logic [15:0] irq_message,
  output int          error_count,
  output int          pending_count,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef struct packed {
    logic        c_write;
    logic [7:0]  c_value;
    logic        irq_fire;
    logic [15:0] irq_message;
  } key_result_t;

  logic [7:0]       ring_copy [RING_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [15:0]      irq_msg_reg;
  key_result_t      expected_results [$];

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    if (int'(idx) == RING_DEPTH - 1) return '0;
    return idx + 1'b1;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = 8'h00;
    wr_ptr = '0;
    rd_ptr = '0;
  endfunction

  function automatic key_result_t store_key(input logic [7:0] code);
    key_result_t r;
    r = '0;
    ring_copy[wr_ptr] = code;
    wr_ptr = next_slot(wr_ptr);
    if (irq_msg_reg != 16'h0000) begin
      r.irq_fire = 1'b1;
      r.irq_message = irq_msg_reg;
    end
    return r;
  endfunction

  function automatic key_result_t predict_result(input logic [1:0] rt, input logic [20:0] ch,
                                                 input logic [7:0] kc, input logic [15:0] a,
                                                 input logic [15:0] b);
    key_result_t r;
    r = '0;
    case (rt)
      kbr_pkg::REQ_CHAR: begin
        if (ch >= kbr_pkg::PRINT_LOW && ch < kbr_pkg::PRINT_END) r = store_key(ch[7:0]);
      end
      kbr_pkg::REQ_KEY: begin
        if (kc != 8'h00) r = store_key(kc);
      end
      kbr_pkg::REQ_CMD: begin
        case (a)
          kbr_pkg::CMD_CLEAR: clear_ring();
          kbr_pkg::CMD_POP: begin
            r.c_write = 1'b1;
            r.c_value = ring_copy[rd_ptr];
            ring_copy[rd_ptr] = 8'h00;
            rd_ptr = next_slot(rd_ptr);
          end
          kbr_pkg::CMD_SET_MSG: irq_msg_reg = b;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    key_result_t got;
    key_result_t want;
    if (rst) begin
      clear_ring();
      irq_msg_reg = 16'h0000;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {c_write, c_value, irq_fire, irq_message};
        checked_count++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got c_write=%0b c_value=0x%0h",
                   $time, got.c_write, got.c_value);
          $display("%0t: unexpected result: irq_fire=%0b irq_message=0x%0h",
                   $time, got.irq_fire, got.irq_message);
        end else begin
          want = expected_results.pop_front();
          check_field("c_write", want.c_write, got.c_write);
          check_field("c_value", want.c_value, got.c_value);
          check_field("irq_fire", want.irq_fire, got.irq_fire);
          check_field("irq_message", want.irq_message, got.irq_message);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(req_type, char_code, key_code, a_reg, b_reg));
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- verif/tb_keyboard_event_ring_device.sv -----
module tb_keyboard_event_ring_device;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH     = 16;
  localparam int          RANDOM_ITEMS   = 500;
  localparam logic [1:0]  REQ_NONE       = 2'd3;
  localparam logic [15:0] CMD_HELD_QUERY = 16'd2;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [20:0] char_code;
  logic [7:0]  key_code;
  logic [15:0] a_reg;
  logic [15:0] b_reg;
  logic        out_valid;
  logic        out_stall;
  logic        c_write;
  logic [7:0]  c_value;
  logic        irq_fire;
  logic [15:0] irq_message;

  int error_count;
  int pending_count;
  int checked_count;
  int n_char;
  int n_key;
  int n_cmd;
  int n_other;
  int stall_left;
  bit idle_mode;

  keyboard_event_ring_device #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .char_code(char_code),
    .key_code(key_code),
    .a_reg(a_reg),
    .b_reg(b_reg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .c_write(c_write),
    .c_value(c_value),
    .irq_fire(irq_fire),
    .irq_message(irq_message)
  );

  kbr_ring_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .char_code(char_code),
    .key_code(key_code),
    .a_reg(a_reg),
    .b_reg(b_reg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .c_write(c_write),
    .c_value(c_value),
    .irq_fire(irq_fire),
    .irq_message(irq_message),
    .error_count(error_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_keyboard_event_ring_device: done, errors");
    $finish;
  end

  // hold off the result channel for a random count after each taken result in idle_mode
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = idle_mode ? $urandom_range(0, 3) : 0;
      else if (stall_left != 0) stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_request(input logic [1:0] rt, input logic [20:0] ch,
                              input logic [7:0] kc, input logic [15:0] a,
                              input logic [15:0] b);
    int gap;
    gap = idle_mode ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rt;
    char_code <= ch;
    key_code  <= kc;
    a_reg     <= a;
    b_reg     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (rt)
      kbr_pkg::REQ_CHAR: n_char++;
      kbr_pkg::REQ_KEY:  n_key++;
      kbr_pkg::REQ_CMD:  n_cmd++;
      default:           n_other++;
    endcase
  endtask

  task automatic send_char(input logic [20:0] ch);
    send_request(kbr_pkg::REQ_CHAR, ch, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_key(input logic [7:0] kc);
    send_request(kbr_pkg::REQ_KEY, 21'($urandom_range(0, 21'h10ffff)), kc, 16'($urandom),
                 16'($urandom));
  endtask

  task automatic send_cmd(input logic [15:0] a, input logic [15:0] b);
    send_request(kbr_pkg::REQ_CMD, 21'($urandom_range(0, 21'h10ffff)), 8'($urandom), a, b);
  endtask

  initial begin
    int sent;
    int burst;
    int pick;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= kbr_pkg::REQ_CHAR;
    char_code <= '0;
    key_code  <= '0;
    a_reg     <= '0;
    b_reg     <= '0;
    idle_mode = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_key(8'h41);
    send_char(kbr_pkg::PRINT_LOW);
    send_char(kbr_pkg::PRINT_END - 1'b1);
    send_char(kbr_pkg::PRINT_LOW - 1'b1);
    send_char(kbr_pkg::PRINT_END);
    send_char(21'h10ffff);
    send_char(21'h000000);
    send_char(21'h000120);
    send_key(8'h00);
    send_key(8'hff);
    send_cmd(kbr_pkg::CMD_SET_MSG, 16'hffff);
    send_key(8'h01);
    send_char(kbr_pkg::PRINT_END - 1'b1);
    send_cmd(CMD_HELD_QUERY, 16'h1234);
    send_cmd(16'hffff, 16'h5555);
    send_request(REQ_NONE, 21'h1fffff, 8'hff, kbr_pkg::CMD_POP, 16'hffff);
    repeat (7) send_cmd(kbr_pkg::CMD_POP, 16'($urandom));
    send_key(8'h5a);
    send_cmd(kbr_pkg::CMD_CLEAR, 16'($urandom));
    send_cmd(kbr_pkg::CMD_POP, 16'($urandom));
    send_cmd(kbr_pkg::CMD_SET_MSG, 16'h0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_mode = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          if ($urandom_range(0, 1) == 0)
            send_char(21'($urandom_range(kbr_pkg::PRINT_LOW, kbr_pkg::PRINT_END - 1'b1)));
          else
            send_key(8'($urandom_range(1, 255)));
        end
      end else if (pick <= 6) begin
        burst = $urandom_range(1, 20);
        repeat (burst) send_cmd(kbr_pkg::CMD_POP, 16'($urandom));
      end else if (pick == 7) begin
        burst = 1;
        send_cmd(kbr_pkg::CMD_SET_MSG,
                 ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom));
      end else if (pick == 8) begin
        burst = 1;
        send_cmd(kbr_pkg::CMD_CLEAR, 16'($urandom));
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          send_request(2'($urandom_range(0, 3)), 21'($urandom_range(0, 21'h10ffff)),
                       8'($urandom),
                       ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom),
                       16'($urandom));
        end
      end
      sent += burst;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 1000 && pending_count != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests: %0d characters, %0d special keys,",
             n_char + n_key + n_cmd + n_other, n_char, n_key);
    $display("%0d host commands, %0d other; %0d results compared, %0d mismatches, %0d open.",
             n_cmd, n_other, checked_count, error_count, pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_keyboard_event_ring_device: done, clean");
    end else begin
      $display("tb_keyboard_event_ring_device: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/kbr_pkg.sv
src/kbr_ram.sv
src/kbr_ctrl.sv
src/kbr_datapath.sv
src/keyboard_event_ring_device.sv
verif/kbr_ring_checker.sv
verif/tb_keyboard_event_ring_device.sv
